@@ hw/rtl/qau_pkg.sv @@
// shared types, constants and rounding helpers for the quaternion arithmetic unit
package qau_pkg;

   localparam logic [2:0] ACT_MUL = 3'd0;
   localparam logic [2:0] ACT_DIV = 3'd1;
   localparam logic [2:0] ACT_DER = 3'd2;
   localparam logic [2:0] ACT_ROT = 3'd3;
   localparam logic [2:0] ACT_NRM = 3'd4;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned DIV_STEPS  = 51;
   localparam int unsigned SQRT_STEPS = 26;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

   localparam logic signed [66:0] ONE_Q48  = 67'sd1 <<< 48;
   localparam logic signed [99:0] HALF_Q24 = 100'sd1 <<< 23;
   localparam logic signed [99:0] HALF_Q25 = 100'sd1 <<< 24;
   localparam logic signed [99:0] HALF_Q48 = 100'sd1 <<< 47;
   localparam logic signed [99:0] SAT_HI   = 100'sd2147483647;
   localparam logic signed [99:0] SAT_LO   = -100'sd2147483648;

   typedef enum logic [2:0] {
      OP_MUL,
      OP_DIV,
      OP_DER,
      OP_ROT,
      OP_NRM,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      RND_Q24,
      RND_Q25,
      RND_Q48
   } rnd_type;

   typedef enum logic [1:0] {
      NRM_IDLE,
      NRM_DIV,
      NRM_SQRT,
      NRM_DONE
   } nrm_state_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      logic signed [31:0] lz;
      logic signed [31:0] lw;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [32:0] rw;
   } item_type;

   typedef struct packed {
      logic             start;
      logic             retire;
      logic [64:0]      s;
      logic [3:0][62:0] sq;
   } nrm_cmd_type;

   typedef struct packed {
      logic             done;
      logic [3:0][24:0] mag;
   } nrm_sts_type;

   function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
      sx33 = {a[31], a};
   endfunction

   // round half up by the mode's shift, then clamp to the signed 32-bit range
   function automatic logic signed [31:0] round_sat(input logic signed [99:0] a,
                                                     input rnd_type mode);
      logic signed [99:0] t;
      case (mode)
         RND_Q24: t = (a + HALF_Q24) >>> 24;
         RND_Q25: t = (a + HALF_Q25) >>> 25;
         RND_Q48: t = (a + HALF_Q48) >>> 48;
         default: t = '0;
      endcase
      if (t > SAT_HI) begin
         round_sat = 32'sh7FFFFFFF;
      end else if (t < SAT_LO) begin
         round_sat = 32'sh80000000;
      end else begin
         round_sat = $signed(t[31:0]);
      end
   endfunction

endpackage

@@ hw/rtl/qau_chan_if.sv @@
// valid/ready channel interfaces for requests and responses
interface qau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [31:0] left_x;
   logic signed [31:0] left_y;
   logic signed [31:0] left_z;
   logic signed [31:0] left_w;
   logic signed [31:0] right_x;
   logic signed [31:0] right_y;
   logic signed [31:0] right_z;
   logic signed [31:0] right_w;

   modport source (output valid, action, left_x, left_y, left_z, left_w,
                   right_x, right_y, right_z, right_w, input ready);
   modport sink (input valid, action, left_x, left_y, left_z, left_w,
                 right_x, right_y, right_z, right_w, output ready);
endinterface

interface qau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_x;
   logic signed [31:0] res_y;
   logic signed [31:0] res_z;
   logic signed [31:0] res_w;
   logic               zero_norm;

   modport source (output valid, res_x, res_y, res_z, res_w, zero_norm, input ready);
   modport sink (input valid, res_x, res_y, res_z, res_w, zero_norm, output ready);
endinterface

@@ hw/rtl/qau_front.sv @@
// request decode: maps the action code to an operation and conditions the right scalar
module qau_front (
   qau_req_if.sink           req_chan,
   output logic              push_valid,
   output qau_pkg::item_type push_item,
   input  logic              push_ready
);
   import qau_pkg::*;

   logic signed [32:0] rw_ext;

   assign rw_ext         = sx33(req_chan.right_w);
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

   always_comb begin
      push_item.lx = req_chan.left_x;
      push_item.ly = req_chan.left_y;
      push_item.lz = req_chan.left_z;
      push_item.lw = req_chan.left_w;
      push_item.rx = req_chan.right_x;
      push_item.ry = req_chan.right_y;
      push_item.rz = req_chan.right_z;
      case (req_chan.action)
         ACT_MUL: begin
            push_item.op = OP_MUL;
            push_item.rw = rw_ext;
         end
         ACT_DIV: begin
            // conjugate scalar, kept one bit wider so the most negative value negates
            push_item.op = OP_DIV;
            push_item.rw = -rw_ext;
         end
         ACT_DER: begin
            push_item.op = OP_DER;
            push_item.rw = '0;
         end
         ACT_ROT: begin
            push_item.op = OP_ROT;
            push_item.rw = '0;
         end
         ACT_NRM: begin
            push_item.op = OP_NRM;
            push_item.rw = '0;
         end
         default: begin
            push_item.op = OP_NOP;
            push_item.rw = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/qau_queue.sv @@
// short fifo between the decode front and the arithmetic back end
module qau_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  qau_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output qau_pkg::item_type pop_item,
   input  logic              pop_ready
);
   import qau_pkg::*;

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/qau_norm.sv @@
// normalize engine: per lane, restoring division of q^2 * 2^50 by the squared norm,
// then a digit-by-digit square root of the quotient
module qau_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  qau_pkg::nrm_cmd_type cmd,
   output qau_pkg::nrm_sts_type sts
);
   import qau_pkg::*;

   nrm_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              load;
   logic [64:0]       s_ff, s_in;
   logic [3:0]        lsb_ff, lsb_in;
   logic [64:0]       rem_ff [4];
   logic [64:0]       rem_in [4];
   logic [51:0]       quo_ff [4];
   logic [51:0]       quo_in [4];
   logic [28:0]       sr_ff [4];
   logic [28:0]       sr_in [4];
   logic [25:0]       root_ff [4];
   logic [25:0]       root_in [4];
   logic [65:0]       div_t [4];
   logic [28:0]       sq_t [4];
   logic [28:0]       trial [4];
   logic [25:0]       rounded [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NRM_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load     = 1'b0;
      case (state_ff)
         NRM_IDLE: begin
            if (cmd.start) begin
               load     = 1'b1;
               step_in  = '0;
               state_in = NRM_DIV;
            end
         end
         NRM_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = NRM_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         NRM_SQRT: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = NRM_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         NRM_DONE: begin
            if (cmd.retire) begin
               state_in = NRM_IDLE;
            end
         end
         default: begin
            state_in = NRM_IDLE;
         end
      endcase
   end

   always_comb begin
      s_in   = s_ff;
      lsb_in = lsb_ff;
      for (int l = 0; l < 4; l++) begin
         // only the first division step brings in the one nonzero low dividend bit
         div_t[l] = {rem_ff[l], (step_ff == '0) ? lsb_ff[l] : 1'b0};
         sq_t[l]  = {sr_ff[l][26:0], quo_ff[l][51:50]};
         trial[l] = {1'b0, root_ff[l], 2'b01};
         rem_in[l]  = rem_ff[l];
         quo_in[l]  = quo_ff[l];
         sr_in[l]   = sr_ff[l];
         root_in[l] = root_ff[l];
         if (load) begin
            rem_in[l]  = {3'b000, cmd.sq[l][62:1]};
            quo_in[l]  = '0;
            sr_in[l]   = '0;
            root_in[l] = '0;
         end else if (state_ff == NRM_DIV) begin
            if (div_t[l] >= {1'b0, s_ff}) begin
               rem_in[l] = 65'(div_t[l] - {1'b0, s_ff});
               quo_in[l] = {quo_ff[l][50:0], 1'b1};
            end else begin
               rem_in[l] = div_t[l][64:0];
               quo_in[l] = {quo_ff[l][50:0], 1'b0};
            end
         end else if (state_ff == NRM_SQRT) begin
            quo_in[l] = {quo_ff[l][49:0], 2'b00};
            if (sq_t[l] >= trial[l]) begin
               sr_in[l]   = sq_t[l] - trial[l];
               root_in[l] = {root_ff[l][24:0], 1'b1};
            end else begin
               sr_in[l]   = sq_t[l];
               root_in[l] = {root_ff[l][24:0], 1'b0};
            end
         end
      end
      if (load) begin
         s_in = cmd.s;
         for (int l = 0; l < 4; l++) begin
            lsb_in[l] = cmd.sq[l][0];
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      lsb_ff <= lsb_in;
      for (int l = 0; l < 4; l++) begin
         rem_ff[l]  <= rem_in[l];
         quo_ff[l]  <= quo_in[l];
         sr_ff[l]   <= sr_in[l];
         root_ff[l] <= root_in[l];
      end
   end

   // odd-root floor to nearest-with-ties-away: (root + 1) / 2
   always_comb begin
      sts.done = (state_ff == NRM_DONE);
      for (int l = 0; l < 4; l++) begin
         rounded[l]  = root_ff[l] + 26'd1;
         sts.mag[l]  = rounded[l][25:1];
      end
   end

endmodule

@@ hw/rtl/qau_back.sv @@
// arithmetic back end: products, sums, split rotate products, accumulate, round and
// saturate, or sign the normalize magnitudes, with the response register at the end
module qau_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  qau_pkg::item_type    pop_item,
   output logic                 pop_ready,
   output qau_pkg::nrm_cmd_type nrm_cmd,
   input  qau_pkg::nrm_sts_type nrm_sts,
   qau_rsp_if.source            rsp_chan
);
   import qau_pkg::*;

   logic en, out_free, nrm_wait, s_nz, load_out;

   // stage 1: products
   logic               p1_valid_ff;
   op_type             p1_op_ff;
   logic signed [64:0] p1_prod_ff [16];
   logic signed [64:0] p1_prod_in [16];
   logic signed [31:0] p1_v_ff [3];
   logic [3:0]         p1_neg_ff;
   logic signed [32:0] opa [16];
   logic signed [31:0] opb [16];

   // stage 2: sums and rotation matrix
   logic               p2_valid_ff;
   op_type             p2_op_ff;
   logic signed [66:0] p2_w_ff [9];
   logic signed [66:0] p2_w_in [9];
   logic signed [31:0] p2_v_ff [3];
   logic [3:0]         p2_neg_ff;
   logic signed [66:0] pe [16];

   // stage 3: matrix times vector, split in halves
   logic               p3_valid_ff;
   op_type             p3_op_ff;
   logic signed [65:0] p3_ph_ff [9];
   logic signed [65:0] p3_ph_in [9];
   logic signed [65:0] p3_pl_ff [9];
   logic signed [65:0] p3_pl_in [9];
   logic signed [66:0] p3_w_ff [5];
   logic [3:0]         p3_neg_ff;

   // stage 4: accumulate
   logic               p4_valid_ff;
   op_type             p4_op_ff;
   logic signed [99:0] p4_acc_ff [4];
   logic signed [99:0] p4_acc_in [4];
   logic [64:0]        p4_s_ff, p4_s_in;
   logic [3:0]         p4_neg_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] res_ff [4];
   logic signed [31:0] res_in [4];
   logic               flag_ff, flag_in;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign s_nz      = (p4_s_ff != '0);
   assign nrm_wait  = p4_valid_ff && (p4_op_ff == OP_NRM) && s_nz && !nrm_sts.done;
   assign en        = out_free && !nrm_wait;
   assign pop_ready = en;
   assign load_out  = en && p4_valid_ff;

   always_comb begin
      nrm_cmd.start  = p4_valid_ff && (p4_op_ff == OP_NRM) && s_nz;
      nrm_cmd.retire = en;
      nrm_cmd.s      = p4_s_ff;
      for (int l = 0; l < 4; l++) begin
         nrm_cmd.sq[l] = p4_acc_ff[l][62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            p1_valid_ff <= pop_valid;
            p2_valid_ff <= p1_valid_ff;
            p3_valid_ff <= p2_valid_ff;
            p4_valid_ff <= p3_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand selection for the sixteen multipliers
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         opa[i] = '0;
         opb[i] = '0;
      end
      case (pop_item.op)
         OP_MUL, OP_DIV, OP_DER: begin
            opa[0]  = pop_item.rw;         opb[0]  = pop_item.lx;
            opa[1]  = sx33(pop_item.rz);   opb[1]  = pop_item.ly;
            opa[2]  = sx33(pop_item.ry);   opb[2]  = pop_item.lz;
            opa[3]  = sx33(pop_item.rx);   opb[3]  = pop_item.lw;
            opa[4]  = pop_item.rw;         opb[4]  = pop_item.ly;
            opa[5]  = sx33(pop_item.rz);   opb[5]  = pop_item.lx;
            opa[6]  = sx33(pop_item.rx);   opb[6]  = pop_item.lz;
            opa[7]  = sx33(pop_item.ry);   opb[7]  = pop_item.lw;
            opa[8]  = sx33(pop_item.ry);   opb[8]  = pop_item.lx;
            opa[9]  = sx33(pop_item.rx);   opb[9]  = pop_item.ly;
            opa[10] = pop_item.rw;         opb[10] = pop_item.lz;
            opa[11] = sx33(pop_item.rz);   opb[11] = pop_item.lw;
            opa[12] = pop_item.rw;         opb[12] = pop_item.lw;
            opa[13] = sx33(pop_item.rx);   opb[13] = pop_item.lx;
            opa[14] = sx33(pop_item.ry);   opb[14] = pop_item.ly;
            opa[15] = sx33(pop_item.rz);   opb[15] = pop_item.lz;
         end
         OP_ROT: begin
            opa[0] = sx33(pop_item.lx);   opb[0] = pop_item.lx;
            opa[1] = sx33(pop_item.ly);   opb[1] = pop_item.ly;
            opa[2] = sx33(pop_item.lz);   opb[2] = pop_item.lz;
            opa[3] = sx33(pop_item.lx);   opb[3] = pop_item.ly;
            opa[4] = sx33(pop_item.lx);   opb[4] = pop_item.lz;
            opa[5] = sx33(pop_item.ly);   opb[5] = pop_item.lz;
            opa[6] = sx33(pop_item.lx);   opb[6] = pop_item.lw;
            opa[7] = sx33(pop_item.ly);   opb[7] = pop_item.lw;
            opa[8] = sx33(pop_item.lz);   opb[8] = pop_item.lw;
         end
         OP_NRM: begin
            opa[0] = sx33(pop_item.lx);   opb[0] = pop_item.lx;
            opa[1] = sx33(pop_item.ly);   opb[1] = pop_item.ly;
            opa[2] = sx33(pop_item.lz);   opb[2] = pop_item.lz;
            opa[3] = sx33(pop_item.lw);   opb[3] = pop_item.lw;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 16; i++) begin
         p1_prod_in[i] = opa[i] * opb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_op_ff  <= pop_item.op;
         p1_v_ff[0] <= pop_item.rx;
         p1_v_ff[1] <= pop_item.ry;
         p1_v_ff[2] <= pop_item.rz;
         p1_neg_ff <= {pop_item.lw[31], pop_item.lz[31], pop_item.ly[31], pop_item.lx[31]};
         for (int i = 0; i < 16; i++) begin
            p1_prod_ff[i] <= p1_prod_in[i];
         end
      end
   end

   // sums; for rotation: ii jj kk ij ik jk ir jr kr sit in products zero to eight
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         pe[i] = 67'(p1_prod_ff[i]);
      end
      for (int i = 0; i < 9; i++) begin
         p2_w_in[i] = '0;
      end
      case (p1_op_ff)
         OP_MUL, OP_DIV, OP_DER: begin
            p2_w_in[0] = pe[0] + pe[1] - pe[2] + pe[3];
            p2_w_in[1] = pe[4] - pe[5] + pe[6] + pe[7];
            p2_w_in[2] = pe[8] - pe[9] + pe[10] + pe[11];
            p2_w_in[3] = pe[12] - pe[13] - pe[14] - pe[15];
         end
         OP_ROT: begin
            p2_w_in[0] = ONE_Q48 - ((pe[1] + pe[2]) <<< 1);
            p2_w_in[1] = (pe[3] - pe[8]) <<< 1;
            p2_w_in[2] = (pe[4] + pe[7]) <<< 1;
            p2_w_in[3] = (pe[3] + pe[8]) <<< 1;
            p2_w_in[4] = ONE_Q48 - ((pe[0] + pe[2]) <<< 1);
            p2_w_in[5] = (pe[5] - pe[6]) <<< 1;
            p2_w_in[6] = (pe[4] - pe[7]) <<< 1;
            p2_w_in[7] = (pe[5] + pe[6]) <<< 1;
            p2_w_in[8] = ONE_Q48 - ((pe[0] + pe[1]) <<< 1);
         end
         OP_NRM: begin
            p2_w_in[0] = pe[0];
            p2_w_in[1] = pe[1];
            p2_w_in[2] = pe[2];
            p2_w_in[3] = pe[3];
            p2_w_in[4] = pe[0] + pe[1] + pe[2] + pe[3];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_op_ff  <= p1_op_ff;
         p2_neg_ff <= p1_neg_ff;
         for (int i = 0; i < 3; i++) begin
            p2_v_ff[i] <= p1_v_ff[i];
         end
         for (int i = 0; i < 9; i++) begin
            p2_w_ff[i] <= p2_w_in[i];
         end
      end
   end

   // matrix element split at bit 33 so each multiplier stays near 32 by 32
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p3_ph_in[3 * r + c] = $signed(p2_w_ff[3 * r + c][66:33]) * p2_v_ff[c];
            p3_pl_in[3 * r + c] = $signed({1'b0, p2_w_ff[3 * r + c][32:0]}) * p2_v_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_op_ff  <= p2_op_ff;
         p3_neg_ff <= p2_neg_ff;
         for (int i = 0; i < 9; i++) begin
            p3_ph_ff[i] <= p3_ph_in[i];
            p3_pl_ff[i] <= p3_pl_in[i];
         end
         for (int i = 0; i < 5; i++) begin
            p3_w_ff[i] <= p2_w_ff[i];
         end
      end
   end

   always_comb begin
      p4_s_in = '0;
      for (int i = 0; i < 4; i++) begin
         p4_acc_in[i] = '0;
      end
      case (p3_op_ff)
         OP_MUL, OP_DIV, OP_DER: begin
            for (int i = 0; i < 4; i++) begin
               p4_acc_in[i] = 100'(p3_w_ff[i]);
            end
         end
         OP_ROT: begin
            for (int r = 0; r < 3; r++) begin
               p4_acc_in[r] = (100'(p3_ph_ff[3 * r]) <<< 33) + 100'(p3_pl_ff[3 * r])
                            + (100'(p3_ph_ff[3 * r + 1]) <<< 33) + 100'(p3_pl_ff[3 * r + 1])
                            + (100'(p3_ph_ff[3 * r + 2]) <<< 33) + 100'(p3_pl_ff[3 * r + 2]);
            end
         end
         OP_NRM: begin
            for (int i = 0; i < 4; i++) begin
               p4_acc_in[i] = 100'(p3_w_ff[i]);
            end
            p4_s_in = p3_w_ff[4][64:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_op_ff  <= p3_op_ff;
         p4_neg_ff <= p3_neg_ff;
         p4_s_ff   <= p4_s_in;
         for (int i = 0; i < 4; i++) begin
            p4_acc_ff[i] <= p4_acc_in[i];
         end
      end
   end

   always_comb begin
      flag_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         res_in[i] = '0;
      end
      case (p4_op_ff)
         OP_MUL, OP_DIV: begin
            for (int i = 0; i < 4; i++) begin
               res_in[i] = round_sat(p4_acc_ff[i], RND_Q24);
            end
         end
         OP_DER: begin
            for (int i = 0; i < 4; i++) begin
               res_in[i] = round_sat(p4_acc_ff[i], RND_Q25);
            end
         end
         OP_ROT: begin
            for (int i = 0; i < 3; i++) begin
               res_in[i] = round_sat(p4_acc_ff[i], RND_Q48);
            end
         end
         OP_NRM: begin
            if (!s_nz) begin
               flag_in = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = p4_neg_ff[i] ? -$signed({7'b0, nrm_sts.mag[i]})
                                           : $signed({7'b0, nrm_sts.mag[i]});
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = out_free ? (p4_valid_ff && !nrm_wait) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         flag_ff <= flag_in;
         for (int i = 0; i < 4; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.res_x     = res_ff[0];
   assign rsp_chan.res_y     = res_ff[1];
   assign rsp_chan.res_z     = res_ff[2];
   assign rsp_chan.res_w     = res_ff[3];
   assign rsp_chan.zero_norm = flag_ff;

endmodule

@@ hw/rtl/quaternion_arithmetic_unit.sv @@
// Quaternion arithmetic unit: multiply, divide, attitude derivative, vector rotate and
// normalize on scalar-last Q8.24 quaternions. A request is decoded and placed in a
// four-entry queue; the back end is a four-stage pipeline (products, sums, split
// rotate products, accumulate) followed by the response register, so every operation
// but normalize is taken one per cycle while the response channel does not stall.
// Normalize with a nonzero norm holds the back end in its last stage while the
// normalize engine runs a 51-step division and a 26-step square root; meanwhile the
// queue keeps taking requests until full.
module quaternion_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   qau_req_if.sink   req_chan,
   qau_rsp_if.source rsp_chan
);
   import qau_pkg::*;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   item_type    push_item, pop_item;
   nrm_cmd_type nrm_cmd;
   nrm_sts_type nrm_sts;

   qau_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   qau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   qau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .nrm_cmd   (nrm_cmd),
      .nrm_sts   (nrm_sts),
      .rsp_chan  (rsp_chan)
   );

   qau_norm u_norm (
      .clock (clock),
      .reset (reset),
      .cmd   (nrm_cmd),
      .sts   (nrm_sts)
   );

endmodule

@@ hw/rtl/qau_checker.sv @@
// port-level checks for the quaternion arithmetic unit, bound to the top level
module qau_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] res_x,
   input logic signed [31:0] res_y,
   input logic signed [31:0] res_z,
   input logic signed [31:0] res_w,
   input logic               zero_norm
);

   // response held until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(res_x) && $stable(res_y) && $stable(res_z)
                                  && $stable(res_w) && $stable(zero_norm))
      else $error("response payload changed while stalled");

   // zero norm flag comes only with all-zero components
   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_norm |-> res_x == 0 && res_y == 0 && res_z == 0 && res_w == 0)
      else $error("zero norm with nonzero components");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty unit after reset cannot answer before a request transfer
   a_no_early_rsp: assert property (@(posedge clock)
      reset ##1 !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response without a request");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .res_x     (rsp_chan.res_x),
   .res_y     (rsp_chan.res_y),
   .res_z     (rsp_chan.res_z),
   .res_w     (rsp_chan.res_w),
   .zero_norm (rsp_chan.zero_norm)
);
